// File: rtl/conic_spiral_surface_eval_unit_macros.svh
// Assertion helpers for the conic spiral surface evaluator.
`ifndef CONIC_SPIRAL_SURFACE_EVAL_UNIT_MACROS_SVH
`define CONIC_SPIRAL_SURFACE_EVAL_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSSE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csse assertion failed");

// Next-cycle implication, disabled during reset.
`define CSSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csse assertion failed");

`endif

// File: rtl/csse_pkg.sv
package csse_pkg;

   localparam int ANGLE_BITS      = 16;
   localparam int SINE_TABLE_BITS = 10;
   localparam int QUARTER_SIZE    = 1 << (SINE_TABLE_BITS - 2);

   localparam logic [63:0]        TWO_PI_Q28     = 64'd1686629713;
   localparam logic signed [23:0] INV_TWO_PI_Q24 = 24'sd2670177;
   localparam logic [63:0]        TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72,
                                                     64'd42, 64'd20, 64'd6};

   localparam int CSR_INDEX_BITS = 8;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIUS_GAIN   = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEIGHT_GAIN   = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OFFSET_GAIN   = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDING_COUNT = 8'd3;

   localparam logic signed [15:0] RADIUS_GAIN_RESET   = 16'sd819;
   localparam logic signed [15:0] HEIGHT_GAIN_RESET   = 16'sd4096;
   localparam logic signed [15:0] OFFSET_GAIN_RESET   = 16'sd410;
   localparam logic signed [15:0] WINDING_COUNT_RESET = 16'sd8192;

   typedef logic [SINE_TABLE_BITS-1:0] sine_index_type;
   typedef logic [24:0]                qsin_entry_type;
   typedef qsin_entry_type             qsin_table_type [QUARTER_SIZE];
   typedef logic signed [25:0]         sine_type;

   typedef struct packed {
      logic [16:0] u_turn;
      logic [16:0] v_turn;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [31:0] du_x;
      logic signed [31:0] du_y;
      logic signed [31:0] du_z;
      logic signed [31:0] dv_x;
      logic signed [31:0] dv_y;
      logic signed [31:0] dv_z;
   } rsp_payload_type;

   // Quarter-wave sine, Q24, from a seven-term Taylor evaluation at elaboration.
   function automatic qsin_table_type build_qsin();
      qsin_table_type t;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] s;
      for (int o = 0; o < QUARTER_SIZE; o++) begin
         x    = (64'(o) * TWO_PI_Q28) >> (SINE_TABLE_BITS - 2);
         x2   = (x * x) >> 30;
         term = 64'd1 << 30;
         for (int i = 0; i < 6; i++) begin
            term = (64'd1 << 30) - ((x2 * term) >> 30) / TAYLOR_DIV[i];
         end
         s    = (x * term) >> 30;
         t[o] = 25'((s + 64'd32) >> 6);
      end
      return t;
   endfunction

   localparam qsin_table_type QSIN_TABLE = build_qsin();

   // Q28 turn fraction -> table index: truncate to the angle width, then to the index.
   function automatic sine_index_type turn_index(input logic [27:0] ph);
      logic [ANGLE_BITS-1:0]                 ang;
      logic [ANGLE_BITS+SINE_TABLE_BITS-1:0] sc;
      ang = ph[27 -: ANGLE_BITS];
      sc  = {ang, {SINE_TABLE_BITS{1'b0}}};
      return sc[ANGLE_BITS +: SINE_TABLE_BITS];
   endfunction

   function automatic sine_type table_sine(input sine_index_type idx);
      logic [1:0]                 quad;
      logic [SINE_TABLE_BITS-3:0] off;
      logic [SINE_TABLE_BITS-2:0] qoff;
      qsin_entry_type             mag;
      quad = idx[SINE_TABLE_BITS-1 -: 2];
      off  = idx[SINE_TABLE_BITS-3:0];
      qoff = quad[0] ? ((SINE_TABLE_BITS-1)'(QUARTER_SIZE) - {1'b0, off}) : {1'b0, off};
      mag  = qoff[SINE_TABLE_BITS-2] ? (25'd1 << 24) : QSIN_TABLE[qoff[SINE_TABLE_BITS-3:0]];
      return quad[1] ? -sine_type'({1'b0, mag}) : sine_type'({1'b0, mag});
   endfunction

   // Product rounded to nearest, ties up (floor shift of the biased value).
   function automatic logic signed [63:0] mul_rnd(input logic signed [63:0] x,
                                                  input logic signed [63:0] y,
                                                  input int sh);
      return (x * y + (64'sd1 <<< (sh - 1))) >>> sh;
   endfunction

   // Q24 -> Q16 rounded, saturated to 32 bits.
   function automatic logic signed [31:0] sat_out(input logic signed [35:0] q);
      logic signed [35:0] v;
      v = (q + 36'sd128) >>> 8;
      if (v > 36'sd2147483647) return 32'sh7fffffff;
      if (v < -36'sd2147483648) return 32'sh80000000;
      return 32'(v);
   endfunction

endpackage

// File: rtl/conic_spiral_surface_eval_unit.sv
// Conic spiral surface evaluator: point, d/du and d/dv for each (u, v) request.
// A request passes through stages 1 to 5 and the output register to rsp_valid.
// Throughput: one request per cycle; the five-stage multiplier pipeline sets it,
// and the whole pipeline holds while a result waits on rsp_ready.
// Reset (synchronous, active high) clears all valid bits and loads the gain
// registers with their defaults; the datapath registers are not reset.
`include "conic_spiral_surface_eval_unit_macros.svh"

module conic_spiral_surface_eval_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  csse_pkg::req_payload_type               req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output csse_pkg::rsp_payload_type               rsp_data,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [csse_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [15:0]                             csr_data
);

   // ---------------------------------------------------------------------
   // Gain registers
   // ---------------------------------------------------------------------
   logic signed [15:0] radius_gain_ff, height_gain_ff, offset_gain_ff, winding_count_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_gain_ff   <= csse_pkg::RADIUS_GAIN_RESET;
         height_gain_ff   <= csse_pkg::HEIGHT_GAIN_RESET;
         offset_gain_ff   <= csse_pkg::OFFSET_GAIN_RESET;
         winding_count_ff <= csse_pkg::WINDING_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         // Drop writes to unknown indexes.
         unique case (csr_index)
            csse_pkg::CSR_RADIUS_GAIN:   radius_gain_ff   <= csr_data;
            csse_pkg::CSR_HEIGHT_GAIN:   height_gain_ff   <= csr_data;
            csse_pkg::CSR_OFFSET_GAIN:   offset_gain_ff   <= csr_data;
            csse_pkg::CSR_WINDING_COUNT: winding_count_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline control: every stage advances together unless the output
   // register holds a result that the consumer has not taken.
   // ---------------------------------------------------------------------
   logic stage_adv;
   logic p1_valid_ff, p2_valid_ff, p3_valid_ff, p4_valid_ff, p5_valid_ff, rsp_valid_ff;

   assign stage_adv = !rsp_valid_ff || rsp_ready;
   assign req_ready = stage_adv;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         p4_valid_ff  <= 1'b0;
         p5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (stage_adv) begin
         p1_valid_ff  <= req_valid;
         p2_valid_ff  <= p1_valid_ff;
         p3_valid_ff  <= p2_valid_ff;
         p4_valid_ff  <= p3_valid_ff;
         p5_valid_ff  <= p4_valid_ff;
         rsp_valid_ff <= p5_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: table indexes for u and n*v, scaled tube radius a*(1-t).
   // ---------------------------------------------------------------------
   csse_pkg::sine_index_type p1_iu_in, p1_iv_in, p1_iu_ff, p1_iv_ff;
   logic signed [29:0] p1_ar_in, p1_ar_ff;
   logic [16:0]        p1_v_ff;
   logic signed [33:0] nv_prod;
   logic signed [18:0] one_minus_v;
   logic signed [34:0] ar_prod;

   always_comb begin
      // Keep the low 28 bits of n*v_turn: that is n*v modulo one turn in Q28.
      nv_prod     = winding_count_ff * $signed({1'b0, req_data.v_turn});
      one_minus_v = 19'sd65536 - $signed({2'b00, req_data.v_turn});
      ar_prod     = radius_gain_ff * one_minus_v;
      p1_ar_in    = 30'((ar_prod + 35'sd8) >>> 4);
      p1_iu_in    = csse_pkg::turn_index({req_data.u_turn[15:0], 12'b0});
      p1_iv_in    = csse_pkg::turn_index(nv_prod[27:0]);
   end

   always_ff @(posedge clock) begin
      if (stage_adv) begin
         p1_iu_ff <= p1_iu_in;
         p1_iv_ff <= p1_iv_in;
         p1_ar_ff <= p1_ar_in;
         p1_v_ff  <= req_data.v_turn;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: table sines and cosines, gain products.
   // ---------------------------------------------------------------------
   csse_pkg::sine_type p2_su_ff, p2_cu_ff, p2_snv_ff, p2_cnv_ff;
   logic signed [29:0] p2_ar_ff;
   logic signed [27:0] p2_k_in, p2_kb_in, p2_k_ff, p2_kb_ff;
   logic signed [29:0] p2_bv_in, p2_bv_ff;
   logic signed [31:0] p2_cn_in, p2_cn_ff;

   always_comb begin
      p2_k_in  = 28'(csse_pkg::mul_rnd(radius_gain_ff, csse_pkg::INV_TWO_PI_Q24, 12));
      p2_kb_in = 28'(csse_pkg::mul_rnd(height_gain_ff, csse_pkg::INV_TWO_PI_Q24, 12));
      // b*t in Q24: Q12 gain times Q16 turns, drop four bits.
      p2_bv_in = 30'(csse_pkg::mul_rnd(height_gain_ff, 64'(p1_v_ff), 4));
      p2_cn_in = offset_gain_ff * winding_count_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_adv) begin
         p2_su_ff  <= csse_pkg::table_sine(p1_iu_ff);
         p2_cu_ff  <= csse_pkg::table_sine(p1_iu_ff + csse_pkg::SINE_TABLE_BITS'(
                         csse_pkg::QUARTER_SIZE));
         p2_snv_ff <= csse_pkg::table_sine(p1_iv_ff);
         p2_cnv_ff <= csse_pkg::table_sine(p1_iv_ff + csse_pkg::SINE_TABLE_BITS'(
                         csse_pkg::QUARTER_SIZE));
         p2_ar_ff  <= p1_ar_ff;
         p2_k_ff   <= p2_k_in;
         p2_kb_ff  <= p2_kb_in;
         p2_bv_ff  <= p2_bv_in;
         p2_cn_ff  <= p2_cn_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: first-level products with the trig terms.
   // ---------------------------------------------------------------------
   logic signed [26:0] p3_opc_in, p3_opc_ff;
   logic signed [30:0] p3_w_ff;
   logic signed [29:0] p3_ar_cnv_ff, p3_ar_snv_ff, p3_ar_su_ff, p3_ar_cu_ff;
   logic signed [27:0] p3_k_cnv_ff, p3_k_snv_ff, p3_k_su_ff, p3_kb_ff;
   logic signed [29:0] p3_c_cnv_ff, p3_c_snv_ff;
   logic signed [31:0] p3_cn_snv_ff, p3_cn_cnv_ff;
   logic signed [29:0] p3_bv_ff;
   csse_pkg::sine_type p3_su_ff, p3_snv_ff, p3_cnv_ff;

   assign p3_opc_in = 27'sd16777216 + 27'(p2_cu_ff);

   always_ff @(posedge clock) begin
      if (stage_adv) begin
         p3_opc_ff    <= p3_opc_in;
         p3_w_ff      <= 31'(csse_pkg::mul_rnd(p2_ar_ff, p3_opc_in, 24));
         p3_ar_cnv_ff <= 30'(csse_pkg::mul_rnd(p2_ar_ff, p2_cnv_ff, 24));
         p3_ar_snv_ff <= 30'(csse_pkg::mul_rnd(p2_ar_ff, p2_snv_ff, 24));
         p3_ar_su_ff  <= 30'(csse_pkg::mul_rnd(p2_ar_ff, p2_su_ff, 24));
         p3_ar_cu_ff  <= 30'(csse_pkg::mul_rnd(p2_ar_ff, p2_cu_ff, 24));
         p3_k_cnv_ff  <= 28'(csse_pkg::mul_rnd(p2_k_ff, p2_cnv_ff, 24));
         p3_k_snv_ff  <= 28'(csse_pkg::mul_rnd(p2_k_ff, p2_snv_ff, 24));
         p3_k_su_ff   <= 28'(csse_pkg::mul_rnd(p2_k_ff, p2_su_ff, 24));
         p3_c_cnv_ff  <= 30'(csse_pkg::mul_rnd(offset_gain_ff, p2_cnv_ff, 12));
         p3_c_snv_ff  <= 30'(csse_pkg::mul_rnd(offset_gain_ff, p2_snv_ff, 12));
         p3_cn_snv_ff <= 32'(csse_pkg::mul_rnd(p2_cn_ff, p2_snv_ff, 24));
         p3_cn_cnv_ff <= 32'(csse_pkg::mul_rnd(p2_cn_ff, p2_cnv_ff, 24));
         p3_kb_ff     <= p2_kb_ff;
         p3_bv_ff     <= p2_bv_ff;
         p3_su_ff     <= p2_su_ff;
         p3_snv_ff    <= p2_snv_ff;
         p3_cnv_ff    <= p2_cnv_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: second-level products.
   // ---------------------------------------------------------------------
   logic signed [32:0] p4_wn_ff;
   logic signed [30:0] p4_w_cnv_ff, p4_w_snv_ff;
   logic signed [29:0] p4_t3_ff, p4_t4_ff, p4_ar_su_ff, p4_ar_cu_ff;
   logic signed [27:0] p4_kco_ff, p4_kso_ff, p4_kb_ff, p4_k_su_ff;
   logic signed [29:0] p4_c_cnv_ff, p4_c_snv_ff;
   logic signed [31:0] p4_cn_snv_ff, p4_cn_cnv_ff;
   logic signed [29:0] p4_bv_ff;
   csse_pkg::sine_type p4_snv_ff, p4_cnv_ff;

   always_ff @(posedge clock) begin
      if (stage_adv) begin
         p4_wn_ff     <= 33'(csse_pkg::mul_rnd(p3_w_ff, winding_count_ff, 12));
         p4_w_cnv_ff  <= 31'(csse_pkg::mul_rnd(p3_w_ff, p3_cnv_ff, 24));
         p4_w_snv_ff  <= 31'(csse_pkg::mul_rnd(p3_w_ff, p3_snv_ff, 24));
         p4_t3_ff     <= 30'(csse_pkg::mul_rnd(p3_ar_cnv_ff, p3_su_ff, 24));
         p4_t4_ff     <= 30'(csse_pkg::mul_rnd(p3_ar_snv_ff, p3_su_ff, 24));
         p4_kco_ff    <= 28'(csse_pkg::mul_rnd(p3_k_cnv_ff, p3_opc_ff, 24));
         p4_kso_ff    <= 28'(csse_pkg::mul_rnd(p3_k_snv_ff, p3_opc_ff, 24));
         p4_ar_su_ff  <= p3_ar_su_ff;
         p4_ar_cu_ff  <= p3_ar_cu_ff;
         p4_kb_ff     <= p3_kb_ff;
         p4_k_su_ff   <= p3_k_su_ff;
         p4_c_cnv_ff  <= p3_c_cnv_ff;
         p4_c_snv_ff  <= p3_c_snv_ff;
         p4_cn_snv_ff <= p3_cn_snv_ff;
         p4_cn_cnv_ff <= p3_cn_cnv_ff;
         p4_bv_ff     <= p3_bv_ff;
         p4_snv_ff    <= p3_snv_ff;
         p4_cnv_ff    <= p3_cnv_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: winding products, two-term sums.
   // ---------------------------------------------------------------------
   logic signed [35:0] p5_r0_ff, p5_r1_ff, p5_r2_ff, p5_r3_ff, p5_r4_ff, p5_r5_ff;
   logic signed [35:0] p5_r8_ff, p5_r6a_ff, p5_r7a_ff;
   logic signed [32:0] p5_wn_snv_ff, p5_wn_cnv_ff;

   always_ff @(posedge clock) begin
      if (stage_adv) begin
         p5_wn_snv_ff <= 33'(csse_pkg::mul_rnd(p4_wn_ff, p4_snv_ff, 24));
         p5_wn_cnv_ff <= 33'(csse_pkg::mul_rnd(p4_wn_ff, p4_cnv_ff, 24));
         p5_r0_ff     <= 36'(p4_w_cnv_ff) + 36'(p4_c_cnv_ff);
         p5_r1_ff     <= 36'(p4_w_snv_ff) + 36'(p4_c_snv_ff);
         p5_r2_ff     <= 36'(p4_bv_ff) + 36'(p4_ar_su_ff);
         p5_r3_ff     <= -36'(p4_t3_ff);
         p5_r4_ff     <= -36'(p4_t4_ff);
         p5_r5_ff     <= 36'(p4_ar_cu_ff);
         p5_r8_ff     <= 36'(p4_kb_ff) - 36'(p4_k_su_ff);
         p5_r6a_ff    <= -36'(p4_kco_ff) - 36'(p4_cn_snv_ff);
         p5_r7a_ff    <= -36'(p4_kso_ff) + 36'(p4_cn_cnv_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Output register: finish the v derivatives, round and saturate.
   // ---------------------------------------------------------------------
   csse_pkg::rsp_payload_type rsp_data_in, rsp_data_ff;

   always_comb begin
      rsp_data_in.point_x = csse_pkg::sat_out(p5_r0_ff);
      rsp_data_in.point_y = csse_pkg::sat_out(p5_r1_ff);
      rsp_data_in.point_z = csse_pkg::sat_out(p5_r2_ff);
      rsp_data_in.du_x    = csse_pkg::sat_out(p5_r3_ff);
      rsp_data_in.du_y    = csse_pkg::sat_out(p5_r4_ff);
      rsp_data_in.du_z    = csse_pkg::sat_out(p5_r5_ff);
      rsp_data_in.dv_x    = csse_pkg::sat_out(p5_r6a_ff - 36'(p5_wn_snv_ff));
      rsp_data_in.dv_y    = csse_pkg::sat_out(p5_r7a_ff + 36'(p5_wn_cnv_ff));
      rsp_data_in.dv_z    = csse_pkg::sat_out(p5_r8_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_data = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `CSSE_ASSERT_IMP(a_stall_blocks_req, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `CSSE_ASSERT_NEXT(a_stage1_holds, clock, reset, p1_valid_ff && !stage_adv, p1_valid_ff)
   `CSSE_ASSERT_IMP(a_gain_defaults, clock, reset, $past(reset), (radius_gain_ff == csse_pkg::RADIUS_GAIN_RESET) && (winding_count_ff == csse_pkg::WINDING_COUNT_RESET))

endmodule

// File: sim/tb_conic_spiral_surface_eval_unit.sv
`timescale 1ns / 1ps

module tb_conic_spiral_surface_eval_unit;
   import csse_pkg::*;

   // Index that maps to no register; writes to it must be dropped.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 8'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOP_INDEX = 8'hff;
   localparam int NUM_GAINS = 4;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_ITEMS = 1550;
   localparam int BLOCK_ITEMS = 130;

   // Predicts each (u, v) evaluation from its own copy of the gain registers
   // and holds the expected surface records in arrival order.
   class point_scoreboard;
      logic signed [15:0] gain [NUM_GAINS];
      longint unsigned    quarter_q30 [QUARTER_SIZE];
      rsp_payload_type    expected_points [$];
      int                 errors;

      function new();
         longint unsigned x, x2, term;
         gain[CSR_RADIUS_GAIN]   = 16'sd819;
         gain[CSR_HEIGHT_GAIN]   = 16'sd4096;
         gain[CSR_OFFSET_GAIN]   = 16'sd410;
         gain[CSR_WINDING_COUNT] = 16'sd8192;
         errors = 0;
         // Quarter-wave sine, Q30, seven-term Taylor in nested form.
         for (int o = 0; o < QUARTER_SIZE; o++) begin
            x  = (longint'(o) * 64'd1686629713) >> (SINE_TABLE_BITS - 2);
            x2 = (x * x) >> 30;
            term = 64'd1 << 30;
            term = (64'd1 << 30) - ((x2 * term) >> 30) / 156;
            term = (64'd1 << 30) - ((x2 * term) >> 30) / 110;
            term = (64'd1 << 30) - ((x2 * term) >> 30) / 72;
            term = (64'd1 << 30) - ((x2 * term) >> 30) / 42;
            term = (64'd1 << 30) - ((x2 * term) >> 30) / 20;
            term = (64'd1 << 30) - ((x2 * term) >> 30) / 6;
            quarter_q30[o] = (x * term) >> 30;
         end
      endfunction

      function void write_gain(logic [CSR_INDEX_BITS-1:0] idx, logic [15:0] value);
         if (idx < NUM_GAINS) gain[idx] = value;
      endfunction

      function int pending();
         return expected_points.size();
      endfunction

      static function longint round_shift(longint x, int sh);
         return (x + (64'sd1 <<< (sh - 1))) >>> sh;
      endfunction

      static function longint mul_q24(longint x, longint y);
         return round_shift(x * y, 24);
      endfunction

      static function logic signed [31:0] to_q16(longint q24);
         longint v;
         v = round_shift(q24, 8);
         if (v > 64'sd2147483647) return 32'sh7fffffff;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return v[31:0];
      endfunction

      // Q28 turn fraction, modulo one turn, truncated to angle then table width.
      static function longint unsigned angle_index(longint unsigned ph);
         longint unsigned ang;
         ang = (ph & 64'h0fff_ffff) >> (28 - ANGLE_BITS);
         return (ang << SINE_TABLE_BITS) >> ANGLE_BITS;
      endfunction

      function longint sine_q24(longint unsigned idx);
         longint unsigned i, quad, off, q, s;
         longint r;
         i    = idx & ((64'd1 << SINE_TABLE_BITS) - 1);
         quad = i >> (SINE_TABLE_BITS - 2);
         off  = i & (QUARTER_SIZE - 1);
         q    = quad[0] ? QUARTER_SIZE - off : off;
         s    = (q >= QUARTER_SIZE) ? (64'd1 << 30) : quarter_q30[q];
         r    = longint'((s + 64'd32) >> 6);
         return quad[1] ? -r : r;
      endfunction

      function rsp_payload_type evaluate(req_payload_type p);
         longint u, v, rg, hg, og, wc, a, b, c, n;
         longint su, cu, snv, cnv, ar, opc, w, k, wn, cn;
         longint unsigned iu, iv;
         longint inv2pi;
         rsp_payload_type e;
         u = p.u_turn;
         v = p.v_turn;
         rg = gain[CSR_RADIUS_GAIN];
         hg = gain[CSR_HEIGHT_GAIN];
         og = gain[CSR_OFFSET_GAIN];
         wc = gain[CSR_WINDING_COUNT];
         a = rg * 4096; b = hg * 4096; c = og * 4096; n = wc * 4096;
         inv2pi = 2670177;
         iu  = angle_index(longint'(u) << 12);
         iv  = angle_index(longint'(wc * v));
         su  = sine_q24(iu);
         cu  = sine_q24(iu + QUARTER_SIZE);
         snv = sine_q24(iv);
         cnv = sine_q24(iv + QUARTER_SIZE);
         ar  = round_shift(rg * (65536 - v), 4);
         opc = (64'sd1 <<< 24) + cu;
         w   = mul_q24(ar, opc);
         k   = mul_q24(a, inv2pi);
         wn  = mul_q24(w, n);
         cn  = mul_q24(c, n);
         e.point_x = to_q16(mul_q24(w, cnv) + mul_q24(c, cnv));
         e.point_y = to_q16(mul_q24(w, snv) + mul_q24(c, snv));
         e.point_z = to_q16(mul_q24(b, v * 256) + mul_q24(ar, su));
         e.du_x = to_q16(-mul_q24(mul_q24(ar, cnv), su));
         e.du_y = to_q16(-mul_q24(mul_q24(ar, snv), su));
         e.du_z = to_q16(mul_q24(ar, cu));
         e.dv_x = to_q16(-mul_q24(mul_q24(k, cnv), opc) - mul_q24(wn, snv)
                         - mul_q24(cn, snv));
         e.dv_y = to_q16(-mul_q24(mul_q24(k, snv), opc) + mul_q24(wn, cnv)
                         + mul_q24(cn, cnv));
         e.dv_z = to_q16(mul_q24(b, inv2pi) - mul_q24(k, su));
         return e;
      endfunction

      function void note_request(req_payload_type p);
         expected_points.push_back(evaluate(p));
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      task check_response(rsp_payload_type got);
         rsp_payload_type want;
         string names [9] = '{"point_x", "point_y", "point_z", "du_x", "du_y",
                              "du_z", "dv_x", "dv_y", "dv_z"};
         if (expected_points.size() == 0) begin
            report("response with no outstanding request");
            return;
         end
         want = expected_points.pop_front();
         for (int j = 0; j < 9; j++) begin
            if (got[(8 - j) * 32 +: 32] !== want[(8 - j) * 32 +: 32])
               report($sformatf("%s got %h want %h", names[j],
                                got[(8 - j) * 32 +: 32], want[(8 - j) * 32 +: 32]));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   point_scoreboard sb = new();
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int stall_count = 0;

   always #4 clock = ~clock;

   conic_spiral_surface_eval_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Receiver back-pressure: decide ready once per cycle at the falling edge.
   always @(negedge clock) begin
      rsp_ready <= (reset || $urandom_range(99) >= rsp_idle_pct);
   end

   // Sample both channels at the rising edge, ahead of any update from the block.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
      end
   end

   // Watchdog: end the run if nothing moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("watchdog expired at %0t", $time);
         $display("conic_spiral_surface_eval_unit test failed");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   // Send one request; called and returning at a falling edge.
   task send_point(input logic [16:0] u, input logic [16:0] v);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data.u_turn = u;
      req_data.v_turn = v;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Hold the sender until every expected result has come, then let the pipe settle.
   task drain();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task write_gain(input logic [CSR_INDEX_BITS-1:0] idx, input logic [15:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      sb.write_gain(idx, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task set_gains(input logic [15:0] r, input logic [15:0] h,
                  input logic [15:0] o, input logic [15:0] w);
      drain();
      write_gain(CSR_RADIUS_GAIN, r);
      write_gain(CSR_HEIGHT_GAIN, h);
      write_gain(CSR_OFFSET_GAIN, o);
      write_gain(CSR_WINDING_COUNT, w);
   endtask

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(7))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hffff;
         4: return 16'($urandom_range(0, 8192)) - 16'd4096;
         default: return 16'($urandom);
      endcase
   endfunction

   logic [16:0] corner_turns [10] = '{17'd0, 17'd1, 17'd16384, 17'd32768, 17'd49152,
                                      17'd65535, 17'd65536, 17'd65537, 17'd98304,
                                      17'd131071};

   function automatic logic [16:0] pick_turn();
      if ($urandom_range(9) == 0) return corner_turns[$urandom_range(9)];
      return 17'($urandom_range(0, 131071));
   endfunction

   initial begin
      int phase_items;
      int sent;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Directed corners at reset gains, then at both gain extremes.
      req_idle_pct = 35;
      rsp_idle_pct = 54;
      for (int i = 0; i < 10; i++) send_point(corner_turns[i], corner_turns[9 - i]);
      for (int i = 0; i < 10; i++) send_point(corner_turns[i], corner_turns[i]);
      set_gains(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      for (int i = 0; i < 3; i++) send_point(corner_turns[3 * i], corner_turns[9 - i]);
      set_gains(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      // An unmapped index must leave every gain untouched.
      drain();
      write_gain(CSR_UNMAPPED, 16'h1234);
      write_gain(CSR_TOP_INDEX, 16'hffff);
      for (int i = 0; i < 3; i++) send_point(corner_turns[9 - 3 * i], corner_turns[i]);

      // Random part in three idling regimes, new gains every block.
      sent = 0;
      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 54 : 0;
         rsp_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 35 : 0;
         phase_items = (phase == 2) ? RANDOM_ITEMS - sent : RANDOM_ITEMS / 3;
         for (int i = 0; i < phase_items; i++) begin
            if (i % BLOCK_ITEMS == 0)
               set_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain());
            // Stretch of back-to-back traffic with no sender gaps.
            if (i % BLOCK_ITEMS == BLOCK_ITEMS / 2 && phase != 2) begin
               req_idle_pct = 0;
            end else if (i % BLOCK_ITEMS == BLOCK_ITEMS - 20) begin
               req_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 54 : 0;
            end
            send_point(pick_turn(), pick_turn());
         end
         sent += phase_items;
      end

      drain();
      while (sb.pending() != 0) begin
         sb.report("expected response never arrived");
         void'(sb.expected_points.pop_front());
      end
      if (sb.errors == 0) begin
         $display("conic_spiral_surface_eval_unit test passed");
      end else begin
         $display("conic_spiral_surface_eval_unit test failed");
      end
      $finish;
   end

endmodule
